@@ sv/ljc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ljc_pkg
// shared widths, codes and types of the lennard-jones plus coulomb pair core
// ----------------------------------------------------------------------------
package ljc_pkg;

	// fraction bits of the squared distance
	localparam int DIST_FRAC_BITS = 24;

	// quotient of 2^(64+F) / r2, its integer square root and the Q.32 reciprocal
	localparam int QUO_W  = 65 + DIST_FRAC_BITS;
	localparam int ROOT_W = (QUO_W + 1) / 2;
	localparam int IR_W   = QUO_W - 32;

	// stages of the back end, output register included
	localparam int FORCE_STAGES = 13;
	localparam int LATENCY      = QUO_W + ROOT_W + FORCE_STAGES;

	// configuration register indexes
	localparam logic [1:0] REG_LJ_REPULSION   = 2'd0;
	localparam logic [1:0] REG_LJ_DISPERSION  = 2'd1;
	localparam logic [1:0] REG_CHARGE_PRODUCT = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// term clamp 2^50 and output rails
	localparam logic [50:0] TERM_CLAMP = 51'h4000000000000;
	localparam logic [47:0] OUT_MAX    = 48'h7FFFFFFFFFFF;
	localparam logic [47:0] OUT_MIN    = 48'h800000000000;

	typedef logic signed [52:0] term_t;

	typedef struct packed {
		logic vld;
		logic zero;
	} ctl_t;

endpackage
`default_nettype wire

@@ sv/lj_coulomb_pair_force_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lj_coulomb_pair_force_core
// 12-6 lennard-jones plus coulomb pair energy and force factor, fixed point
// ----------------------------------------------------------------------------
// usage
//   input: pulse start with dist_squared (unsigned Q8.24); the transaction is
//   taken at a clock edge with start high and busy low. busy is only high
//   from reset until the first clock after reset release.
//   output: done is high for one cycle with pair_energy, coulomb_energy,
//   force_factor (signed Q24.24) and status; the receiver cannot stall.
//   config: cfg_wr_en, cfg_index, cfg_data write A, B or q;
//   write only while no transaction is in flight.
// throughput: one transaction per clock, every clock while busy is low.
// pipeline: the divider (one quotient bit per stage, F = 24 fraction bits) feeds
//   the square root (one root bit per stage); the back end adds 13 stages of
//   32x32 products.
// reset: clears the pipeline valid bits and the three config registers.
// ----------------------------------------------------------------------------
module lj_coulomb_pair_force_core import ljc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [31:0]        dist_squared,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [47:0]        cfg_data,
	output logic                    done,
	output logic signed [47:0]      pair_energy,
	output logic signed [47:0]      coulomb_energy,
	output logic signed [47:0]      force_factor,
	output logic        [1:0]       status
);

	// coefficient registers
	logic [47:0] lj_repulsion_q;
	logic [39:0] lj_dispersion_q;
	logic [31:0] charge_product_q;
	logic        ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lj_repulsion_q   <= '0;
			lj_dispersion_q  <= '0;
			charge_product_q <= '0;
			ready_q          <= 1'b0;
		end else begin
			ready_q <= 1'b1;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_LJ_REPULSION:   lj_repulsion_q   <= cfg_data;
					REG_LJ_DISPERSION:  lj_dispersion_q  <= cfg_data[39:0];
					REG_CHARGE_PRODUCT: charge_product_q <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

	assign busy = !ready_q;

	// reciprocal front end: 2^(64+F)/r2, then its square root
	ctl_t              div_ctl, sqrt_ctl;
	logic [QUO_W-1:0]  div_quo;
	logic [ROOT_W-1:0] sqrt_root;
	logic [IR_W-1:0]   sqrt_ir;

	ljc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.in_x    (dist_squared),
		.out_ctl (div_ctl),
		.out_quo (div_quo)
	);

	ljc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (div_ctl),
		.in_quo   (div_quo),
		.out_ctl  (sqrt_ctl),
		.out_root (sqrt_root),
		.out_ir   (sqrt_ir)
	);

	// power chain, terms and saturation
	ljc_force u_force (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ctl         (sqrt_ctl),
		.in_root        (sqrt_root),
		.in_ir          (sqrt_ir),
		.cfg_a          (lj_repulsion_q),
		.cfg_b          (lj_dispersion_q),
		.cfg_q          (charge_product_q),
		.done           (done),
		.pair_energy    (pair_energy),
		.coulomb_energy (coulomb_energy),
		.force_factor   (force_factor),
		.status         (status)
	);

`ifndef ASSERT_OFF
	// every accepted transaction is followed by done
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction did not complete on time");

	// no result without a matching accepted transaction
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching transaction");

	// zero distance gives all-zero results
	a_zero_results: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_ZERO) |->
			(pair_energy == '0 && coulomb_energy == '0 && force_factor == '0))
		else $error("zero distance with nonzero results");

	// saturation status means a result sits on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_SAT) |->
			(pair_energy == OUT_MAX || pair_energy == OUT_MIN ||
			 force_factor == OUT_MAX || force_factor == OUT_MIN))
		else $error("saturation flagged without a clamped result");
`endif

endmodule
`default_nettype wire

@@ sv/ljc_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ljc_mul
// 64x64 unsigned multiplier, four 32x32 partial products then one summing stage
// ----------------------------------------------------------------------------
module ljc_mul (
	input  wire logic         clk,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic      [127:0] p
);

	logic [63:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1;

	always_ff @(posedge clk) begin
		pp00_s1 <= a[31:0]  * b[31:0];
		pp01_s1 <= a[31:0]  * b[63:32];
		pp10_s1 <= a[63:32] * b[31:0];
		pp11_s1 <= a[63:32] * b[63:32];
		p       <= {pp11_s1, pp00_s1} + {32'd0, pp01_s1, 32'd0} + {32'd0, pp10_s1, 32'd0};
	end

endmodule
`default_nettype wire

@@ sv/ljc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ljc_div
// pipelined restoring divider, one quotient bit per stage: 2^(64+F) / r2
// ----------------------------------------------------------------------------
module ljc_div import ljc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire logic [31:0]      in_x,
	output ctl_t                  out_ctl,
	output logic      [QUO_W-1:0] out_quo
);

	ctl_t             ctl_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [31:0]      x_s   [QUO_W-1];
	logic [31:0]      rem_s [QUO_W-1];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		ctl_t             ctl_in;
		logic [31:0]      x_in;
		logic [31:0]      rem_in;
		logic [QUO_W-1:0] quo_in;
		logic [32:0]      part;
		logic             ge;

		if (k == 0) begin : g_first
			assign ctl_in = '{vld: in_vld, zero: (in_x == 32'd0)};
			assign x_in   = in_x;
			assign rem_in = '0;
			assign quo_in = '0;
		end else begin : g_next
			assign ctl_in = ctl_s[k-1];
			assign x_in   = x_s[k-1];
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// the dividend is a single one at its top bit
		assign part = {rem_in, (k == 0)};
		assign ge   = (part >= {1'b0, x_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k] <= {quo_in[QUO_W-2:0], ge};
		end

		if (k < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				x_s[k]   <= x_in;
				rem_s[k] <= ge ? 32'(part - {1'b0, x_in}) : part[31:0];
			end
		end
	end

	assign out_ctl = ctl_s[QUO_W-1];
	assign out_quo = quo_s[QUO_W-1];

endmodule
`default_nettype wire

@@ sv/ljc_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ljc_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module ljc_sqrt import ljc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  ctl_t                   in_ctl,
	input  wire logic [QUO_W-1:0]  in_quo,
	output ctl_t                   out_ctl,
	output logic      [ROOT_W-1:0] out_root,
	output logic      [IR_W-1:0]   out_ir
);

	localparam int PAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	ctl_t              ctl_s  [ROOT_W];
	logic [PAD_W-1:0]  rad_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W-1];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		ctl_t              ctl_in;
		logic [PAD_W-1:0]  rad_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W-1:0]  rem_in;
		logic [REM_W+1:0]  part;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign ctl_in  = in_ctl;
			assign rad_in  = PAD_W'(in_quo);
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign ctl_in  = ctl_s[j-1];
			assign rad_in  = rad_s[j-1];
			assign root_in = root_s[j-1];
			assign rem_in  = rem_s[j-1];
		end

		assign part  = {rem_in, rad_in[PAD_W-1-2*j -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (part >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else begin
				ctl_s[j] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[j]  <= rad_in;
			root_s[j] <= {root_in[ROOT_W-2:0], ge};
		end

		if (j < ROOT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[j] <= ge ? REM_W'(part - trial) : part[REM_W-1:0];
			end
		end
	end

	assign out_ctl  = ctl_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];
	assign out_ir   = rad_s[ROOT_W-1][QUO_W-1:32];

endmodule
`default_nettype wire

@@ sv/ljc_force.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ljc_force
// power chain, lj and coulomb terms, clamping and output saturation
// ----------------------------------------------------------------------------
module ljc_force import ljc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  ctl_t                    in_ctl,
	input  wire logic [ROOT_W-1:0]  in_root,
	input  wire logic [IR_W-1:0]    in_ir,
	input  wire logic [47:0]        cfg_a,
	input  wire logic [39:0]        cfg_b,
	input  wire logic [31:0]        cfg_q,
	output logic                    done,
	output logic signed [47:0]      pair_energy,
	output logic signed [47:0]      coulomb_energy,
	output logic signed [47:0]      force_factor,
	output logic        [1:0]       status
);

	localparam term_t TERM_POS = term_t'({2'b00, TERM_CLAMP});
	localparam term_t TERM_NEG = -TERM_POS;

	function automatic logic [50:0] clamp_mag(input logic [95:0] hi);
		return (hi > 96'(TERM_CLAMP)) ? TERM_CLAMP : hi[50:0];
	endfunction

	function automatic term_t signed_term(input logic neg, input logic [50:0] mag);
		term_t m;
		m = term_t'({2'b00, mag});
		return neg ? -m : m;
	endfunction

	// the user must keep the configuration static while items are in flight; the block does not enforce it
	logic        qneg, a_nz, lj_on;
	logic [31:0] qmag;
	logic [47:0] bq;
	logic [50:0] bq6;

	assign qneg  = cfg_q[31];
	assign qmag  = qneg ? (~cfg_q) + 32'd1 : cfg_q;
	assign a_nz  = |cfg_a;
	assign lj_on = a_nz | (|cfg_b);
	assign bq    = {cfg_b, 8'h00};
	assign bq6   = {1'b0, bq, 2'b00} + {2'b00, bq, 1'b0};

	// control pipeline
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	ctl_t ctl_s9, ctl_s10, ctl_s11, ctl_s12;

	// payload pipeline
	logic              close_s1, close_s2, close_s3, close_s4, close_s5, close_s6;
	logic              close_s7, close_s8, close_s9, close_s10, close_s11;
	logic [IR_W-1:0]   ir_s1, ir_s2;
	logic [ROOT_W-1:0] ecm_s3, ecm_s4, ecm_s5, ecm_s6, ecm_s7, ecm_s8, ecm_s9, ecm_s10;
	logic [50:0]       cfm_s5, cfm_s6, cfm_s7, cfm_s8, cfm_s9, cfm_s10;
	logic [55:0]       i6_s5, i6_s6, i6_s7, i6_s8;
	logic [63:0]       i8_s5, i8_s6, i8_s7, i8_s8;
	logic [107:0]      p12_s7;
	logic [62:0]       ta_s7;
	logic [62:0]       tm_s8, um_s8;
	logic              tneg_s8, tneg_s9, tneg_s10;
	logic              uneg_s8, uneg_s9, uneg_s10;
	logic              steep_s8, steep_s9, steep_s10;
	term_t             elj_s11, flj_s11, ec_s11, cf_s11;
	term_t             e_s12, f_s12, ec_s12;

	logic [127:0] p1, p2, p3, p4, p5, p6, p7, p8;

	// coulomb energy magnitude q/r and powers of 1/r2
	logic [ROOT_W-1:0] ecm;
	logic [47:0]       i4;
	logic [63:0]       i8;
	logic [55:0]       i6;

	assign ecm = p1[32 +: ROOT_W];
	assign i4  = p2[79:32];
	assign i8  = p4[95:32];
	assign i6  = p5[87:32];

	ljc_mul u_m1 (.clk(clk), .a(64'(qmag)),        .b(64'(in_root)),     .p(p1));
	ljc_mul u_m2 (.clk(clk), .a(64'(in_ir[39:0])), .b(64'(in_ir[39:0])), .p(p2));
	ljc_mul u_m3 (.clk(clk), .a(64'(ecm)),         .b(64'(ir_s2)),       .p(p3));
	ljc_mul u_m4 (.clk(clk), .a(64'(i4)),          .b(64'(i4)),          .p(p4));
	ljc_mul u_m5 (.clk(clk), .a(64'(i4)),          .b(64'(ir_s2[39:0])), .p(p5));
	ljc_mul u_m6 (.clk(clk), .a(64'(cfg_a)),       .b(64'(i6)),          .p(p6));
	ljc_mul u_m7 (.clk(clk), .a(64'(tm_s8)),       .b(64'(i6_s8)),       .p(p7));
	ljc_mul u_m8 (.clk(clk), .a(64'(um_s8)),       .b(64'(i8_s8)),       .p(p8));

	// lj coefficient differences
	logic [62:0] ua;
	logic        tneg, uneg, steep;
	logic [62:0] tm, um;

	assign ua    = p12_s7[86:24];
	assign steep = |p12_s7[107:87];
	assign tneg  = (ta_s7 < 63'(bq));
	assign tm    = tneg ? 63'(bq) - ta_s7 : ta_s7 - 63'(bq);
	assign uneg  = (ua > 63'(bq6));
	assign um    = uneg ? ua - 63'(bq6) : 63'(bq6) - ua;

	// output saturation
	logic        e_ovf, f_ovf;
	logic [47:0] e_val, f_val;

	assign e_ovf = !((&e_s12[52:47]) || !(|e_s12[52:47]));
	assign f_ovf = !((&f_s12[52:47]) || !(|f_s12[52:47]));
	assign e_val = e_ovf ? (e_s12[52] ? OUT_MIN : OUT_MAX) : e_s12[47:0];
	assign f_val = f_ovf ? (f_s12[52] ? OUT_MIN : OUT_MAX) : f_s12[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
			ctl_s12 <= '0;
			done    <= 1'b0;
		end else begin
			ctl_s1  <= in_ctl;
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= ctl_s3;
			ctl_s5  <= ctl_s4;
			ctl_s6  <= ctl_s5;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
			ctl_s12 <= ctl_s11;
			done    <= ctl_s12.vld;
		end
	end

	always_ff @(posedge clk) begin
		// s1..s2: 1/r and 1/r^4 products
		close_s1 <= |in_ir[IR_W-1:40];
		ir_s1    <= in_ir;
		close_s2 <= close_s1;
		ir_s2    <= ir_s1;
		// s3..s4: coulomb force, 1/r^8 and 1/r^6
		close_s3 <= close_s2;
		ecm_s3   <= ecm;
		close_s4 <= close_s3;
		ecm_s4   <= ecm_s3;
		// s5..s6: A times 1/r^6
		close_s5 <= close_s4 | i8[63];
		ecm_s5   <= ecm_s4;
		cfm_s5   <= clamp_mag(p3[127:32]);
		i6_s5    <= i6;
		i8_s5    <= i8;
		close_s6 <= close_s5;
		ecm_s6   <= ecm_s5;
		cfm_s6   <= cfm_s5;
		i6_s6    <= i6_s5;
		i8_s6    <= i8_s5;
		// s7: 12A/r^6 by shift and add
		p12_s7   <= {p6[104:0], 3'b000} + {1'b0, p6[104:0], 2'b00};
		ta_s7    <= p6[86:24];
		close_s7 <= close_s6;
		ecm_s7   <= ecm_s6;
		cfm_s7   <= cfm_s6;
		i6_s7    <= i6_s6;
		i8_s7    <= i8_s6;
		// s8: signed coefficient differences
		tm_s8    <= tm;
		um_s8    <= um;
		tneg_s8  <= tneg;
		uneg_s8  <= uneg;
		steep_s8 <= steep;
		close_s8 <= close_s7;
		ecm_s8   <= ecm_s7;
		cfm_s8   <= cfm_s7;
		i6_s8    <= i6_s7;
		i8_s8    <= i8_s7;
		// s9..s10: lj energy and force products
		tneg_s9   <= tneg_s8;
		uneg_s9   <= uneg_s8;
		steep_s9  <= steep_s8;
		close_s9  <= close_s8;
		ecm_s9    <= ecm_s8;
		cfm_s9    <= cfm_s8;
		tneg_s10  <= tneg_s9;
		uneg_s10  <= uneg_s9;
		steep_s10 <= steep_s9;
		close_s10 <= close_s9;
		ecm_s10   <= ecm_s9;
		cfm_s10   <= cfm_s9;
		// s11: clamped signed terms
		elj_s11   <= steep_s10 ? TERM_POS : signed_term(tneg_s10, clamp_mag(p7[127:32]));
		flj_s11   <= steep_s10 ? TERM_NEG : signed_term(uneg_s10, clamp_mag(p8[127:32]));
		ec_s11    <= signed_term(qneg, 51'(ecm_s10));
		cf_s11    <= signed_term(!qneg, cfm_s10);
		close_s11 <= close_s10;
		// s12: lj plus coulomb (coulomb only when lj is off), core overlap override
		ec_s12 <= ec_s11;
		priority if (!lj_on) begin
			e_s12 <= ec_s11;
			f_s12 <= cf_s11;
		end else if (close_s11) begin
			e_s12 <= a_nz ? TERM_POS : TERM_NEG;
			f_s12 <= a_nz ? TERM_NEG : TERM_POS;
		end else begin
			e_s12 <= elj_s11 + ec_s11;
			f_s12 <= flj_s11 + cf_s11;
		end
		// s13: output register
		if (ctl_s12.zero) begin
			pair_energy    <= '0;
			coulomb_energy <= '0;
			force_factor   <= '0;
			status         <= ST_ZERO;
		end else begin
			pair_energy    <= e_val;
			coulomb_energy <= ec_s12[47:0];
			force_factor   <= f_val;
			status         <= (e_ovf || f_ovf) ? ST_SAT : ST_OK;
		end
	end

endmodule
`default_nettype wire
